// File: hdl/rris_pkg.sv
// shared types and constants for the round-robin i/o scheduler
// no dependencies; used by every module of the block
`default_nettype none

package rris_pkg;

    localparam int SLOT_W        = 4;
    localparam int SLOT_CNT      = 1 << SLOT_W;
    localparam int NUM_SLOTS_DEF = 16;
    localparam logic [7:0] SLICE_RESET = 8'd5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ADMIT = 2'd1,
        CMD_BLOCK = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_GRANT = 2'd0,
        KIND_WAKE  = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        LOC_NONE   = 2'd0,
        LOC_RUN    = 2'd1,
        LOC_RETIRE = 2'd2,
        LOC_WAIT   = 2'd3
    } loc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GRANT,
        ST_AGE,
        ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ADMIT,
        OP_BLOCK,
        OP_ROTATE,
        OP_SWAP,
        OP_GRANT,
        OP_AGE_STEP,
        OP_AGE_END,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        cmd_t cmd;
        logic run_empty;
        logic retire_empty;
        logic front_spent;
        logic age_done;
        logic out_valid;
    } status_t;

    // register index, taken from the word address bit of paddr
    localparam logic ADDR_TIME_SLICE = 1'b0;

endpackage

`default_nettype wire

// File: hdl/round_robin_io_scheduler_top.sv
// A request (start high while busy low) is a tick, an admit or a block. Admit,
// block and unused codes show a single no-action result; so does a tick that
// finds the run queue empty and swaps in the retire queue. Any other tick goes
// through a grant step (skipped when run and retire are both empty) and then
// aging, where the sequencer ages the wait queue one entry a cycle, before its
// last result. Results appear on valid with kind and task_res, at most one per
// cycle, the final one marked by last, and cannot be held off. busy stays high
// until the last result has been shown, so the next request is accepted in the
// cycle after it at the earliest.
// top level: apb register, sequencer and datapath; depends on rris_pkg,
// rris_ctrl and rris_dp
`default_nettype none

module round_robin_io_scheduler_top #(
    parameter int NUM_SLOTS = rris_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  cmd,
    input  wire logic [rris_pkg::SLOT_W-1:0] slot,
    input  wire logic [7:0]                  io_ticks,
    output logic                             valid,
    output logic [1:0]                       kind,
    output logic [rris_pkg::SLOT_W-1:0]      task_res,
    output logic                             last,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [7:0]        time_slice_reg;
    rris_pkg::op_t     op;
    rris_pkg::status_t stat;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rris_pkg::ADDR_TIME_SLICE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= rris_pkg::SLICE_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            time_slice_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_sel ? {24'd0, time_slice_reg} : 32'd0;

    rris_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    rris_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cmd        (cmd),
        .slot       (slot),
        .io_ticks   (io_ticks),
        .time_slice (time_slice_reg),
        .stat       (stat),
        .valid      (valid),
        .kind       (kind),
        .task_res   (task_res),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: hdl/rris_ctrl.sv
// sequencer for the scheduler: walks one request through decode, grant,
// aging and result flush; depends on rris_pkg
`default_nettype none

module rris_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire rris_pkg::status_t  stat,
    output rris_pkg::op_t           op,
    output logic                    busy
);

    rris_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rris_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rris_pkg::ST_IDLE:
            begin
                if (start && !stat.out_valid)
                begin
                    state_next = rris_pkg::ST_DECODE;
                end
            end
            rris_pkg::ST_DECODE:
            begin
                if (stat.cmd != rris_pkg::CMD_TICK)
                begin
                    state_next = rris_pkg::ST_FLUSH;
                end
                else if (!stat.run_empty)
                begin
                    state_next = rris_pkg::ST_GRANT;
                end
                else if (!stat.retire_empty)
                begin
                    state_next = rris_pkg::ST_FLUSH;
                end
                else
                begin
                    state_next = rris_pkg::ST_AGE;
                end
            end
            rris_pkg::ST_GRANT: state_next = rris_pkg::ST_AGE;
            rris_pkg::ST_AGE:
            begin
                if (stat.age_done)
                begin
                    state_next = rris_pkg::ST_FLUSH;
                end
            end
            rris_pkg::ST_FLUSH: state_next = rris_pkg::ST_IDLE;
            default:            state_next = rris_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op = rris_pkg::OP_NONE;
        case (state_reg)
            rris_pkg::ST_IDLE:
            begin
                if (start && !stat.out_valid)
                begin
                    op = rris_pkg::OP_LATCH;
                end
            end
            rris_pkg::ST_DECODE:
            begin
                case (stat.cmd)
                    rris_pkg::CMD_ADMIT: op = rris_pkg::OP_ADMIT;
                    rris_pkg::CMD_BLOCK: op = rris_pkg::OP_BLOCK;
                    rris_pkg::CMD_TICK:
                    begin
                        if (!stat.run_empty)
                        begin
                            op = stat.front_spent ? rris_pkg::OP_ROTATE : rris_pkg::OP_NONE;
                        end
                        else if (!stat.retire_empty)
                        begin
                            op = rris_pkg::OP_SWAP;
                        end
                    end
                    default: op = rris_pkg::OP_NONE;
                endcase
            end
            rris_pkg::ST_GRANT: op = rris_pkg::OP_GRANT;
            rris_pkg::ST_AGE:
                op = stat.age_done ? rris_pkg::OP_AGE_END : rris_pkg::OP_AGE_STEP;
            rris_pkg::ST_FLUSH: op = rris_pkg::OP_FLUSH;
            default:            op = rris_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != rris_pkg::ST_IDLE) || stat.out_valid;

endmodule

`default_nettype wire

// File: hdl/rris_dp.sv
// scheduler datapath: run, retire and wait queues, per-slot counters,
// pending result buffer and result register; depends on rris_pkg
`default_nettype none

module rris_dp #(
    parameter int NUM_SLOTS = rris_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rris_pkg::op_t              op,
    input  wire logic [1:0]                 cmd,
    input  wire logic [rris_pkg::SLOT_W-1:0] slot,
    input  wire logic [7:0]                 io_ticks,
    input  wire logic [7:0]                 time_slice,
    output rris_pkg::status_t               stat,
    output logic                            valid,
    output logic [1:0]                      kind,
    output logic [rris_pkg::SLOT_W-1:0]     task_res,
    output logic                            last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int SW    = rris_pkg::SLOT_W;

    typedef logic [SW-1:0] slot_t;

    rris_pkg::cmd_t cmd_reg;
    slot_t          slot_reg;
    logic [7:0]     io_reg;

    slot_t run_q_reg [NUM_SLOTS];
    slot_t ret_q_reg [NUM_SLOTS];
    slot_t wait_q_reg[NUM_SLOTS];
    slot_t run_q_next [NUM_SLOTS];
    slot_t ret_q_next [NUM_SLOTS];
    slot_t wait_q_next[NUM_SLOTS];
    logic [CNT_W-1:0] run_cnt_reg, ret_cnt_reg, wait_cnt_reg;
    logic [CNT_W-1:0] run_cnt_next, ret_cnt_next, wait_cnt_next;
    logic [CNT_W-1:0] age_idx_reg, keep_reg, age_idx_next, keep_next;

    logic [7:0] slice_reg [rris_pkg::SLOT_CNT];
    logic [7:0] io_left_reg[rris_pkg::SLOT_CNT];
    logic [7:0] slice_next [rris_pkg::SLOT_CNT];
    logic [7:0] io_left_next[rris_pkg::SLOT_CNT];
    rris_pkg::loc_t loc_reg [rris_pkg::SLOT_CNT];
    rris_pkg::loc_t loc_next[rris_pkg::SLOT_CNT];

    logic           pend_v_reg, pend_v_next;
    rris_pkg::kind_t pend_kind_reg, pend_kind_next;
    slot_t          pend_task_reg, pend_task_next;
    logic           out_v_reg, out_v_next;
    rris_pkg::kind_t out_kind_reg, out_kind_next;
    slot_t          out_task_reg, out_task_next;
    logic           out_last_reg, out_last_next;

    slot_t      front;
    slot_t      new_front;
    slot_t      age_slot;
    logic       slot_ok;
    logic       emit_en;
    rris_pkg::kind_t emit_kind;
    slot_t      emit_task;
    logic [IDX_W-1:0] blk_pos;
    logic [CNT_W-1:0] run_less;

    assign front    = run_q_reg[0];
    assign age_slot = wait_q_reg[age_idx_reg[IDX_W-1:0]];
    assign slot_ok  = (32'(slot_reg) < NUM_SLOTS);
    assign run_less = run_cnt_reg - CNT_W'(1);

    // position of the blocking slot inside the run queue
    always_comb
    begin
        blk_pos = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < run_cnt_reg) && (run_q_reg[i] == slot_reg))
            begin
                blk_pos = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        run_q_next    = run_q_reg;
        ret_q_next    = ret_q_reg;
        wait_q_next   = wait_q_reg;
        run_cnt_next  = run_cnt_reg;
        ret_cnt_next  = ret_cnt_reg;
        wait_cnt_next = wait_cnt_reg;
        age_idx_next  = age_idx_reg;
        keep_next     = keep_reg;
        slice_next    = slice_reg;
        io_left_next  = io_left_reg;
        loc_next      = loc_reg;
        new_front     = front;
        emit_en       = 1'b0;
        emit_kind     = rris_pkg::KIND_GRANT;
        emit_task     = front;

        case (op)
            rris_pkg::OP_LATCH:
            begin
                age_idx_next = '0;
                keep_next    = '0;
            end
            rris_pkg::OP_ADMIT:
            begin
                if (slot_ok && (loc_reg[slot_reg] == rris_pkg::LOC_NONE))
                begin
                    slice_next[slot_reg] = time_slice;
                    run_q_next[run_cnt_reg[IDX_W-1:0]] = slot_reg;
                    run_cnt_next = run_cnt_reg + CNT_W'(1);
                    loc_next[slot_reg] = rris_pkg::LOC_RUN;
                end
            end
            rris_pkg::OP_BLOCK:
            begin
                if (slot_ok && (loc_reg[slot_reg] == rris_pkg::LOC_RUN))
                begin
                    for (int i = 0; i < NUM_SLOTS - 1; i++)
                    begin
                        if (IDX_W'(i) >= blk_pos)
                        begin
                            run_q_next[i] = run_q_reg[i+1];
                        end
                    end
                    run_cnt_next = run_less;
                    io_left_next[slot_reg] = io_reg;
                    wait_q_next[wait_cnt_reg[IDX_W-1:0]] = slot_reg;
                    wait_cnt_next = wait_cnt_reg + CNT_W'(1);
                    loc_next[slot_reg] = rris_pkg::LOC_WAIT;
                end
            end
            rris_pkg::OP_ROTATE:
            begin
                for (int i = 0; i < NUM_SLOTS - 1; i++)
                begin
                    run_q_next[i] = run_q_reg[i+1];
                end
                if (run_less == '0)
                begin
                    // run drains: retire plus the old front becomes the run queue
                    run_q_next = ret_q_reg;
                    run_q_next[ret_cnt_reg[IDX_W-1:0]] = front;
                    ret_q_next   = run_q_reg;
                    run_cnt_next = ret_cnt_reg + CNT_W'(1);
                    ret_cnt_next = '0;
                    for (int s = 0; s < rris_pkg::SLOT_CNT; s++)
                    begin
                        if (loc_reg[s] == rris_pkg::LOC_RETIRE)
                        begin
                            loc_next[s] = rris_pkg::LOC_RUN;
                        end
                    end
                    new_front = (ret_cnt_reg == '0) ? front : ret_q_reg[0];
                end
                else
                begin
                    ret_q_next[ret_cnt_reg[IDX_W-1:0]] = front;
                    ret_cnt_next = ret_cnt_reg + CNT_W'(1);
                    run_cnt_next = run_less;
                    loc_next[front] = rris_pkg::LOC_RETIRE;
                    new_front = run_q_reg[1 % NUM_SLOTS];
                end
                slice_next[new_front] = time_slice;
            end
            rris_pkg::OP_SWAP:
            begin
                run_q_next   = ret_q_reg;
                ret_q_next   = run_q_reg;
                run_cnt_next = ret_cnt_reg;
                ret_cnt_next = run_cnt_reg;
                for (int s = 0; s < rris_pkg::SLOT_CNT; s++)
                begin
                    if (loc_reg[s] == rris_pkg::LOC_RETIRE)
                    begin
                        loc_next[s] = rris_pkg::LOC_RUN;
                    end
                end
                slice_next[ret_q_reg[0]] = time_slice;
            end
            rris_pkg::OP_GRANT:
            begin
                if (slice_reg[front] != 8'd0)
                begin
                    slice_next[front] = slice_reg[front] - 8'd1;
                    emit_en   = 1'b1;
                    emit_kind = rris_pkg::KIND_GRANT;
                    emit_task = front;
                end
            end
            rris_pkg::OP_AGE_STEP:
            begin
                age_idx_next = age_idx_reg + CNT_W'(1);
                if (io_left_reg[age_slot] <= 8'd1)
                begin
                    io_left_next[age_slot] = 8'd0;
                    slice_next[age_slot]   = time_slice;
                    run_q_next[run_cnt_reg[IDX_W-1:0]] = age_slot;
                    run_cnt_next = run_cnt_reg + CNT_W'(1);
                    loc_next[age_slot] = rris_pkg::LOC_RUN;
                    emit_en   = 1'b1;
                    emit_kind = rris_pkg::KIND_WAKE;
                    emit_task = age_slot;
                end
                else
                begin
                    io_left_next[age_slot] = io_left_reg[age_slot] - 8'd1;
                    wait_q_next[keep_reg[IDX_W-1:0]] = age_slot;
                    keep_next = keep_reg + CNT_W'(1);
                end
            end
            rris_pkg::OP_AGE_END: wait_cnt_next = keep_reg;
            default: ;
        endcase
    end

    // one result is held back so the final one can carry last
    always_comb
    begin
        pend_v_next    = pend_v_reg;
        pend_kind_next = pend_kind_reg;
        pend_task_next = pend_task_reg;
        out_v_next     = 1'b0;
        out_kind_next  = pend_kind_reg;
        out_task_next  = pend_task_reg;
        out_last_next  = 1'b0;
        if (emit_en)
        begin
            out_v_next     = pend_v_reg;
            pend_v_next    = 1'b1;
            pend_kind_next = emit_kind;
            pend_task_next = emit_task;
        end
        else if (op == rris_pkg::OP_FLUSH)
        begin
            out_v_next    = 1'b1;
            out_last_next = 1'b1;
            pend_v_next   = 1'b0;
            if (!pend_v_reg)
            begin
                out_kind_next = rris_pkg::KIND_NONE;
                out_task_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg  <= '0;
            ret_cnt_reg  <= '0;
            wait_cnt_reg <= '0;
            age_idx_reg  <= '0;
            keep_reg     <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            for (int s = 0; s < rris_pkg::SLOT_CNT; s++)
            begin
                loc_reg[s] <= rris_pkg::LOC_NONE;
            end
        end
        else
        begin
            run_cnt_reg  <= run_cnt_next;
            ret_cnt_reg  <= ret_cnt_next;
            wait_cnt_reg <= wait_cnt_next;
            age_idx_reg  <= age_idx_next;
            keep_reg     <= keep_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
            loc_reg      <= loc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == rris_pkg::OP_LATCH)
        begin
            cmd_reg  <= rris_pkg::cmd_t'(cmd);
            slot_reg <= slot;
            io_reg   <= io_ticks;
        end
        run_q_reg     <= run_q_next;
        ret_q_reg     <= ret_q_next;
        wait_q_reg    <= wait_q_next;
        slice_reg     <= slice_next;
        io_left_reg   <= io_left_next;
        pend_kind_reg <= pend_kind_next;
        pend_task_reg <= pend_task_next;
        out_kind_reg  <= out_kind_next;
        out_task_reg  <= out_task_next;
        out_last_reg  <= out_last_next;
    end

    // fields in status_t order: cmd, run_empty, retire_empty, front_spent,
    // age_done, out_valid
    assign stat = {cmd_reg,
                   (run_cnt_reg == '0),
                   (ret_cnt_reg == '0),
                   (slice_reg[front] == 8'd0),
                   (age_idx_reg == wait_cnt_reg),
                   out_v_reg};

    assign valid    = out_v_reg;
    assign kind     = out_kind_reg;
    assign task_res = out_task_reg;
    assign last     = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/rris_checker.sv
// port-level checks for the scheduler, bound to the top level
// depends on rris_pkg and round_robin_io_scheduler_top
`default_nettype none

module rris_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       valid,
    input wire logic [1:0] kind,
    input wire logic       last
);

    // a result only shows while a request is in flight
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result outside a request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request not busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid) else $error("result after last");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == rris_pkg::KIND_NONE) |-> last)
        else $error("no-action result not final");

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (kind == rris_pkg::KIND_GRANT || kind == rris_pkg::KIND_WAKE ||
                   kind == rris_pkg::KIND_NONE)) else $error("bad result kind");

endmodule

bind round_robin_io_scheduler_top rris_checker u_rris_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .kind  (kind),
    .last  (last)
);

`default_nettype wire

// File: tb/round_robin_io_scheduler_top_tb.sv
// self-checking testbench for the round-robin i/o scheduler top level
// drives ticks, admits, blocks and unused codes through start/busy and checks every result
// against a local scheduler model; depends on rris_pkg and the block's rtl
`timescale 1ns / 100ps
`default_nettype none

module round_robin_io_scheduler_top_tb;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] slot;
        logic [7:0] io_ticks;
    } sched_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] task_res;
        logic       last;
    } sched_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    wire         busy;
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [7:0]  io_ticks;
    wire         valid;
    wire  [1:0]  kind;
    wire  [3:0]  task_res;
    wire         last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    round_robin_io_scheduler_top #(.NUM_SLOTS(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .slot(slot), .io_ticks(io_ticks),
        .valid(valid), .kind(kind), .task_res(task_res), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // scheduler model state
    logic [7:0] slice_reg;
    logic [3:0] run_q[$];
    logic [3:0] retire_q[$];
    logic [3:0] wait_q[$];
    logic [7:0] slice_left[NSLOT];
    logic [7:0] io_left[NSLOT];

    sched_req_t pending_reqs[$];
    sched_res_t expected_res[$];
    int         mismatches;
    bit         drive_en;
    bit         quiet_mode;
    bit         hold_for_drain;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic bit in_q(ref logic [3:0] q[$], input logic [3:0] s);
        foreach (q[i])
            if (q[i] == s)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic push_result(input logic [1:0] k, input logic [3:0] t);
        sched_res_t r;
        r.kind = k;
        r.task_res = t;
        r.last = 1'b0;
        expected_res.push_back(r);
    endtask

    task automatic age_waiters();
        logic [3:0] keep[$];
        foreach (wait_q[i])
        begin
            if (io_left[wait_q[i]] <= 8'd1)
            begin
                io_left[wait_q[i]] = 8'd0;
                slice_left[wait_q[i]] = slice_reg;
                run_q.push_back(wait_q[i]);
                push_result(rris_pkg::KIND_WAKE, wait_q[i]);
            end
            else
            begin
                io_left[wait_q[i]]--;
                keep.push_back(wait_q[i]);
            end
        end
        wait_q = keep;
    endtask

    task automatic swap_queues();
        logic [3:0] tmp[$];
        tmp = run_q;
        run_q = retire_q;
        retire_q = tmp;
    endtask

    task automatic schedule_request(input sched_req_t rq);
        int   n0;
        int   idx;
        logic [3:0] front;
        sched_res_t r;
        n0 = expected_res.size();
        case (rq.cmd)
            rris_pkg::CMD_ADMIT:
            begin
                if (!in_q(run_q, rq.slot) && !in_q(retire_q, rq.slot) &&
                    !in_q(wait_q, rq.slot))
                begin
                    slice_left[rq.slot] = slice_reg;
                    run_q.push_back(rq.slot);
                end
            end
            rris_pkg::CMD_BLOCK:
            begin
                idx = -1;
                foreach (run_q[i])
                    if (idx < 0 && run_q[i] == rq.slot)
                        idx = i;
                if (idx >= 0)
                begin
                    run_q.delete(idx);
                    io_left[rq.slot] = rq.io_ticks;
                    wait_q.push_back(rq.slot);
                end
            end
            rris_pkg::CMD_TICK:
            begin
                if (run_q.size() > 0)
                begin
                    front = run_q[0];
                    if (slice_left[front] == 8'd0)
                    begin
                        void'(run_q.pop_front());
                        retire_q.push_back(front);
                        if (run_q.size() == 0)
                            swap_queues();
                        slice_left[run_q[0]] = slice_reg;
                    end
                    front = run_q[0];
                    if (slice_left[front] != 8'd0)
                    begin
                        slice_left[front]--;
                        push_result(rris_pkg::KIND_GRANT, front);
                    end
                    age_waiters();
                end
                else if (retire_q.size() > 0)
                begin
                    swap_queues();
                    slice_left[run_q[0]] = slice_reg;
                end
                else
                begin
                    age_waiters();
                end
            end
            default:
            begin
            end
        endcase
        if (expected_res.size() == n0)
            push_result(rris_pkg::KIND_NONE, 4'd0);
        r = expected_res[$];
        r.last = 1'b1;
        expected_res[$] = r;
    endtask

    // driver: one request per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !busy)
        begin
            schedule_request({cmd, slot, io_ticks});
            if (drive_en && !hold_for_drain && pending_reqs.size() > 0 &&
                (quiet_mode || $urandom_range(99) >= 7))
            begin
                {cmd, slot, io_ticks} <= pending_reqs.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start && drive_en && !hold_for_drain && pending_reqs.size() > 0 &&
                 (quiet_mode || $urandom_range(99) >= 7))
        begin
            {cmd, slot, io_ticks} <= pending_reqs.pop_front();
            start <= 1'b1;
        end
    end

    // monitor: results cannot be stalled, so check every strobe
    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && valid)
        begin
            if (expected_res.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d task %0d",
                                          kind, task_res));
            end
            else
            begin
                want = expected_res.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (task_res !== want.task_res)
                    report_mismatch($sformatf("task_res %0d, want %0d",
                                              task_res, want.task_res));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    task automatic add_req(input rris_pkg::cmd_t c, input int s, input int io);
        sched_req_t rq;
        rq.cmd = c;
        rq.slot = s[3:0];
        rq.io_ticks = io[7:0];
        pending_reqs.push_back(rq);
    endtask

    task automatic drain();
        drive_en = 1'b1;
        while (pending_reqs.size() > 0 || start || busy || expected_res.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        drive_en = 1'b0;
    endtask

    task automatic write_slice(input logic [7:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rris_pkg::ADDR_TIME_SLICE, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        slice_reg = v;
        // read back through the data port once the write has landed
        @(posedge clk);
        if (pready !== 1'b1)
            report_mismatch("pready low");
        if (prdata !== {24'h0, v})
            report_mismatch($sformatf("prdata %0h, want %0h", prdata, v));
    endtask

    // random phase: mostly admits and ticks with some blocking and noise
    task automatic add_random(input int count);
        int p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(99);
            if (p < 25)
                add_req(rris_pkg::CMD_ADMIT, $urandom_range(15), $urandom_range(255));
            else if (p < 40)
                add_req(rris_pkg::CMD_BLOCK, $urandom_range(15),
                        ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6));
            else if (p < 95)
                add_req(rris_pkg::CMD_TICK, $urandom_range(15), $urandom_range(255));
            else
                add_req(rris_pkg::CMD_NOP, $urandom_range(15), $urandom_range(255));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd = '0;
        slot = '0;
        io_ticks = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        drive_en = 1'b0;
        quiet_mode = 1'b0;
        hold_for_drain = 1'b0;
        slice_reg = rris_pkg::SLICE_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            slice_left[i] = 8'd0;
            io_left[i] = 8'd0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset slice, empty ticks, duplicates, blocks, unknown code
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_ADMIT, 0, 0);
        add_req(rris_pkg::CMD_ADMIT, 15, 255);
        add_req(rris_pkg::CMD_ADMIT, 0, 0);
        add_req(rris_pkg::CMD_BLOCK, 7, 3);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_BLOCK, 15, 0);
        add_req(rris_pkg::CMD_NOP, 15, 255);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_ADMIT, 15, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_BLOCK, 0, 255);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        drain();

        // zero slice: fronts are never granted and keep rotating
        write_slice(8'd0);
        add_req(rris_pkg::CMD_ADMIT, 3, 0);
        add_req(rris_pkg::CMD_ADMIT, 4, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_BLOCK, 3, 1);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        add_req(rris_pkg::CMD_TICK, 0, 0);
        drain();

        write_slice(8'd255);
        add_random(60);
        drain();

        write_slice(8'd1);
        add_random(120);
        drain();

        write_slice(8'd2);
        quiet_mode = 1'b1;
        add_random(100);
        drain();
        quiet_mode = 1'b0;

        write_slice(8'd3);
        add_random(150);
        drive_en = 1'b1;
        while (pending_reqs.size() > 75)
            @(posedge clk);
        // let every outstanding result arrive before sending more
        hold_for_drain = 1'b1;
        while (start || busy || expected_res.size() > 0)
            @(posedge clk);
        hold_for_drain = 1'b0;
        drain();

        write_slice(8'd5);
        add_random(70);
        drain();

        if (mismatches == 0)
            $display("** round_robin_io_scheduler_top: PASSED **");
        else
            $display("** round_robin_io_scheduler_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("** round_robin_io_scheduler_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/rris_pkg.sv
hdl/rris_ctrl.sv
hdl/rris_dp.sv
hdl/round_robin_io_scheduler_top.sv
hdl/rris_checker.sv
tb/round_robin_io_scheduler_top_tb.sv
